// ===== sv/jse_pkg.sv =====
// Shared types, constants and byte classification for the JSON string escaper.
`timescale 1ns / 1ps

package jse_pkg;

    localparam int TOK_MAX   = 4;
    localparam int TOK_CNT_W = $clog2(TOK_MAX + 1);
    localparam int TOK_IDX_W = $clog2(TOK_MAX);
    localparam int QUE_DEPTH = 4;
    localparam int QUE_PTR_W = $clog2(QUE_DEPTH);
    localparam int QUE_CNT_W = $clog2(QUE_DEPTH + 1);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;

    localparam logic [7:0] LEAD_E0 = 8'he0;
    localparam logic [7:0] MIN_E0  = 8'ha0;
    localparam logic [7:0] LEAD_ED = 8'hed;
    localparam logic [7:0] MAX_ED  = 8'h9f;
    localparam logic [7:0] LEAD_F0 = 8'hf0;
    localparam logic [7:0] MIN_F0  = 8'h90;
    localparam logic [7:0] LEAD_F4 = 8'hf4;
    localparam logic [7:0] MAX_F4  = 8'h8f;
    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_HI = 8'hf4;
    localparam logic [7:0] CONT_MASK = 8'hc0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // One queued word group: optional opening quote, up to four byte tokens,
    // optional closing quote. A raw token passes its byte; otherwise the
    // byte goes through the escape rules.
    typedef struct packed {
        logic                        open_q;
        logic                        close_q;
        logic [TOK_CNT_W-1:0]        tok_cnt;
        logic [TOK_MAX-1:0]          tok_raw;
        logic [TOK_MAX-1:0][7:0]     tok_byte;
    } jse_entry_t;

    typedef enum logic [1:0] {
        SEG_OPEN,
        SEG_TOK,
        SEG_CLOSE
    } jse_seg_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            n = 3'd2;
        end else if (b >= LEAD_E0 && b <= LEAD3_HI) begin
            n = 3'd3;
        end else if (b >= LEAD_F0 && b <= LEAD4_HI) begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return seq_len(b) != 3'd0;
    endfunction

endpackage

// ===== sv/jse_queue.sv =====
// Small FIFO of classified word groups between front and back.
`timescale 1ns / 1ps

module jse_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  jse_pkg::jse_entry_t push_entry,
    input  logic                pop,
    output jse_pkg::jse_entry_t head,
    output logic                not_empty,
    output logic                full
);

    jse_pkg::jse_entry_t                  mem [jse_pkg::QUE_DEPTH];
    logic [jse_pkg::QUE_PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [jse_pkg::QUE_PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [jse_pkg::QUE_CNT_W-1:0]        count_reg, count_next;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == jse_pkg::QUE_CNT_W'(jse_pkg::QUE_DEPTH);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/jse_front.sv =====
// Input side: UTF-8 sequence tracking and classification into byte tokens.
`timescale 1ns / 1ps

module jse_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_string_start,
    input  logic                s_string_end,
    input  logic                s_no_byte,
    input  logic                q_full,
    output logic                q_push,
    output jse_pkg::jse_entry_t q_entry
);

    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic [1:0]                      cnt_eff;
        logic [2:0]                      need;
        logic                            ok;
        logic [jse_pkg::TOK_CNT_W-1:0]   tcnt;
        jse_pkg::jse_entry_t             ent;

        cnt_eff   = s_string_start ? 2'd0 : cnt_reg;
        held_next = held_reg;
        cnt_next  = cnt_eff;
        ent       = '0;
        tcnt      = '0;
        ent.open_q = s_string_start;

        need = jse_pkg::seq_len(held_reg[0]);
        ok   = (need != 3'd0)
            && ((s_data_byte & jse_pkg::CONT_MASK) == jse_pkg::CONT_TAG)
            && ({1'b0, cnt_eff} < need);
        if (cnt_eff == 2'd1) begin
            if (held_reg[0] == jse_pkg::LEAD_E0 && s_data_byte < jse_pkg::MIN_E0) ok = 1'b0;
            if (held_reg[0] == jse_pkg::LEAD_ED && s_data_byte > jse_pkg::MAX_ED) ok = 1'b0;
            if (held_reg[0] == jse_pkg::LEAD_F0 && s_data_byte < jse_pkg::MIN_F0) ok = 1'b0;
            if (held_reg[0] == jse_pkg::LEAD_F4 && s_data_byte > jse_pkg::MAX_F4) ok = 1'b0;
        end

        if (!s_no_byte) begin
            if (cnt_eff == 2'd0) begin
                if (jse_pkg::is_lead(s_data_byte)) begin
                    held_next[0] = s_data_byte;
                    cnt_next     = 2'd1;
                end else begin
                    ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = s_data_byte;
                    tcnt = tcnt + 1'b1;
                end
            end else if (ok && ({1'b0, cnt_eff} + 3'd1 == need)) begin
                // complete sequence: release held bytes and this one unchanged
                ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = held_reg[0];
                ent.tok_raw[tcnt[jse_pkg::TOK_IDX_W-1:0]]  = 1'b1;
                tcnt = tcnt + 1'b1;
                if (cnt_eff >= 2'd2) begin
                    ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = held_reg[1];
                    ent.tok_raw[tcnt[jse_pkg::TOK_IDX_W-1:0]]  = 1'b1;
                    tcnt = tcnt + 1'b1;
                end
                if (cnt_eff == 2'd3) begin
                    ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = held_reg[2];
                    ent.tok_raw[tcnt[jse_pkg::TOK_IDX_W-1:0]]  = 1'b1;
                    tcnt = tcnt + 1'b1;
                end
                ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = s_data_byte;
                ent.tok_raw[tcnt[jse_pkg::TOK_IDX_W-1:0]]  = 1'b1;
                tcnt     = tcnt + 1'b1;
                cnt_next = 2'd0;
            end else if (ok) begin
                held_next[cnt_eff] = s_data_byte;
                cnt_next           = cnt_eff + 2'd1;
            end else begin
                // broken sequence: escape every held byte, restart with this one
                ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = held_reg[0];
                tcnt = tcnt + 1'b1;
                if (cnt_eff >= 2'd2) begin
                    ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = held_reg[1];
                    tcnt = tcnt + 1'b1;
                end
                if (cnt_eff == 2'd3) begin
                    ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = held_reg[2];
                    tcnt = tcnt + 1'b1;
                end
                cnt_next = 2'd0;
                if (jse_pkg::is_lead(s_data_byte)) begin
                    held_next[0] = s_data_byte;
                    cnt_next     = 2'd1;
                end else begin
                    ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = s_data_byte;
                    tcnt = tcnt + 1'b1;
                end
            end
        end

        if (s_string_end) begin
            // flush whatever is still held, escaped
            if (cnt_next >= 2'd1) begin
                ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = held_next[0];
                tcnt = tcnt + 1'b1;
            end
            if (cnt_next >= 2'd2) begin
                ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = held_next[1];
                tcnt = tcnt + 1'b1;
            end
            if (cnt_next == 2'd3) begin
                ent.tok_byte[tcnt[jse_pkg::TOK_IDX_W-1:0]] = held_next[2];
                tcnt = tcnt + 1'b1;
            end
            cnt_next    = 2'd0;
            ent.close_q = 1'b1;
        end

        ent.tok_cnt = tcnt;
        q_entry     = ent;
        q_push      = accept && (ent.open_q || ent.close_q || tcnt != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== sv/jse_back.sv =====
// Output side: expands queued tokens into escaped output words.
`timescale 1ns / 1ps

module jse_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  jse_pkg::jse_entry_t q_head,
    input  logic                q_not_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_run_last,
    output logic                m_string_done
);

    jse_pkg::jse_entry_t                 cur_reg, cur_next;
    logic                                cur_valid_reg, cur_valid_next;
    jse_pkg::jse_seg_t                   seg_reg, seg_next;
    logic [jse_pkg::TOK_IDX_W-1:0]       tok_idx_reg, tok_idx_next;
    logic [2:0]                          chr_idx_reg, chr_idx_next;
    logic                                m_valid_reg, m_valid_next;
    logic [7:0]                          m_out_byte_reg;
    logic                                m_run_last_reg, m_string_done_reg;
    logic                                step;
    logic [7:0]                          ch;
    logic                                done;
    logic                                fin;

    function automatic logic [7:0] esc_char(input logic [7:0] b);
        logic [7:0] e;
        unique case (b)
            8'h22:   e = 8'h22;
            8'h5c:   e = 8'h5c;
            8'h08:   e = 8'h62;
            8'h0c:   e = 8'h66;
            8'h0a:   e = 8'h6e;
            8'h0d:   e = 8'h72;
            8'h09:   e = 8'h74;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
    endfunction

    function automatic logic [2:0] tok_len(input logic raw, input logic [7:0] b);
        logic [2:0] n;
        if (raw) begin
            n = 3'd1;
        end else if (esc_char(b) != 8'h00) begin
            n = 3'd2;
        end else if (b < 8'h20 || b >= 8'h80) begin
            n = 3'd6;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

    function automatic logic [7:0] tok_char(input logic raw, input logic [7:0] b,
                                           input logic [2:0] k);
        logic [7:0] c;
        logic [7:0] e;
        e = esc_char(b);
        c = b;
        if (!raw && e != 8'h00) begin
            c = (k == 3'd0) ? jse_pkg::CH_BACKSLASH : e;
        end else if (!raw && (b < 8'h20 || b >= 8'h80)) begin
            unique case (k)
                3'd0:    c = jse_pkg::CH_BACKSLASH;
                3'd1:    c = jse_pkg::CH_U;
                3'd2:    c = jse_pkg::CH_ZERO;
                3'd3:    c = jse_pkg::CH_ZERO;
                3'd4:    c = hex_digit(b[7:4]);
                default: c = hex_digit(b[3:0]);
            endcase
        end
        return c;
    endfunction

    function automatic jse_pkg::jse_seg_t first_seg(input jse_pkg::jse_entry_t e);
        jse_pkg::jse_seg_t s;
        if (e.open_q) begin
            s = jse_pkg::SEG_OPEN;
        end else if (e.tok_cnt != '0) begin
            s = jse_pkg::SEG_TOK;
        end else begin
            s = jse_pkg::SEG_CLOSE;
        end
        return s;
    endfunction

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_run_last    = m_run_last_reg;
    assign m_string_done = m_string_done_reg;

    assign step = cur_valid_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg       <= jse_pkg::SEG_OPEN;
            cur_valid_reg <= 1'b0;
            tok_idx_reg   <= '0;
            chr_idx_reg   <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            seg_reg       <= seg_next;
            cur_valid_reg <= cur_valid_next;
            tok_idx_reg   <= tok_idx_next;
            chr_idx_reg   <= chr_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (step) begin
            m_out_byte_reg    <= ch;
            m_run_last_reg    <= fin;
            m_string_done_reg <= done;
        end
    end

    always_comb begin
        jse_pkg::jse_seg_t              a_seg;
        logic [jse_pkg::TOK_IDX_W-1:0]  a_tok;
        logic [2:0]                     a_chr;
        logic                           tk_raw;
        logic [7:0]                     tk_byte;
        logic [2:0]                     tk_len;

        tk_raw  = cur_reg.tok_raw[tok_idx_reg];
        tk_byte = cur_reg.tok_byte[tok_idx_reg];
        tk_len  = tok_len(tk_raw, tk_byte);

        a_seg = seg_reg;
        a_tok = tok_idx_reg;
        a_chr = chr_idx_reg;
        ch    = jse_pkg::CH_QUOTE;
        done  = 1'b0;
        fin   = 1'b0;

        unique case (seg_reg)
            jse_pkg::SEG_OPEN: begin
                ch = jse_pkg::CH_QUOTE;
                if (cur_reg.tok_cnt != '0) begin
                    a_seg = jse_pkg::SEG_TOK;
                    a_tok = '0;
                    a_chr = 3'd0;
                end else if (cur_reg.close_q) begin
                    a_seg = jse_pkg::SEG_CLOSE;
                end else begin
                    fin = 1'b1;
                end
            end
            jse_pkg::SEG_TOK: begin
                ch = tok_char(tk_raw, tk_byte, chr_idx_reg);
                if (chr_idx_reg != tk_len - 3'd1) begin
                    a_chr = chr_idx_reg + 3'd1;
                end else if ({1'b0, tok_idx_reg} + 1'b1 < cur_reg.tok_cnt) begin
                    a_tok = tok_idx_reg + 1'b1;
                    a_chr = 3'd0;
                end else if (cur_reg.close_q) begin
                    a_seg = jse_pkg::SEG_CLOSE;
                end else begin
                    fin = 1'b1;
                end
            end
            jse_pkg::SEG_CLOSE: begin
                ch   = jse_pkg::CH_QUOTE;
                done = 1'b1;
                fin  = 1'b1;
            end
            default: begin
                fin = 1'b1;
            end
        endcase

        seg_next       = seg_reg;
        tok_idx_next   = tok_idx_reg;
        chr_idx_next   = chr_idx_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        q_pop          = 1'b0;

        if (step) begin
            seg_next     = a_seg;
            tok_idx_next = a_tok;
            chr_idx_next = a_chr;
            if (fin) begin
                cur_valid_next = 1'b0;
            end
        end

        // load the next group as soon as the current one has gone out
        if ((!cur_valid_reg || (step && fin)) && q_not_empty) begin
            q_pop          = 1'b1;
            cur_next       = q_head;
            cur_valid_next = 1'b1;
            seg_next       = first_seg(q_head);
            tok_idx_next   = '0;
            chr_idx_next   = 3'd0;
        end

        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

endmodule

// ===== sv/json_string_escaper_utf8_check.sv =====
// Top level of the JSON string escaper with UTF-8 checking.
//
// Bytes enter on the s_ channel, one word per cycle while s_ready is high, and leave
// as the characters of a quoted JSON string literal on the m_ channel, one character
// per cycle while m_ready is high. The input side tracks held UTF-8 bytes and takes a
// new word every cycle while its four-entry queue has room; a word that expands to N
// characters (up to 25) holds the output for all N, so the sustained input rate
// follows the output character stream. A word is registered in the queue, then in
// the current-group register, then in the output register. Words that produce no
// characters (a held lead or continuation byte) put nothing in the queue or output.
`timescale 1ns / 1ps

module json_string_escaper_utf8_check (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_string_start,
    input  logic       s_string_end,
    input  logic       s_no_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_string_done
);

    jse_pkg::jse_entry_t push_entry;
    jse_pkg::jse_entry_t head;
    logic                push;
    logic                pop;
    logic                not_empty;
    logic                full;

    jse_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_string_start (s_string_start),
        .s_string_end   (s_string_end),
        .s_no_byte      (s_no_byte),
        .q_full         (full),
        .q_push         (push),
        .q_entry        (push_entry)
    );

    jse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .full       (full)
    );

    jse_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_head        (head),
        .q_not_empty   (not_empty),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_string_done (m_string_done)
    );

endmodule
